FILE: sv/gls_pkg.sv
package gls_pkg;

   localparam logic [31:0] QNAN32    = 32'h7FC0_0000;
   localparam logic [31:0] INF32     = 32'h7F80_0000;
   localparam logic [31:0] BF16_BIAS = 32'h0000_7FFF;
   localparam logic [15:0] F16_QNAN  = 16'h7E00;
   localparam logic [15:0] F16_INF   = 16'h7C00;
   localparam logic [7:0]  F32_EMAX  = 8'hFF;
   localparam logic [4:0]  F16_EMAX  = 5'h1F;

   function automatic logic is_nan32(input logic [31:0] b);
      return (b[30:23] == F32_EMAX) && (b[22:0] != '0);
   endfunction

   function automatic logic is_inf32(input logic [31:0] b);
      return (b[30:23] == F32_EMAX) && (b[22:0] == '0);
   endfunction

   function automatic logic is_zero32(input logic [31:0] b);
      return b[30:0] == '0;
   endfunction

   function automatic logic [23:0] unp_man(input logic [31:0] b);
      return (b[30:23] == '0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
   endfunction

   function automatic logic signed [11:0] unp_exp(input logic [31:0] b);
      return (b[30:23] == '0) ? -12'sd149 : ($signed({4'b0, b[30:23]}) - 12'sd150);
   endfunction

   // Priority search for the position of the top set bit, plus one.
   function automatic logic [6:0] bit_len64(input logic [63:0] v);
      logic [6:0] n;
      n = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) n = 7'(i + 1);
      end
      return n;
   endfunction

   // Round r * 2^e (top bit count nb) to fb fraction bits, nearest even,
   // gradual underflow, overflow to infinity. sign is already in place.
   function automatic logic [31:0] round_pack(input logic [31:0] sign,
                                              input logic [63:0] r,
                                              input logic signed [11:0] e,
                                              input logic [6:0] nb,
                                              input int fb, input int bias,
                                              input int emax);
      logic signed [12:0] q;
      logic signed [12:0] minq;
      logic signed [12:0] drop;
      logic signed [12:0] biased;
      logic [63:0] m;
      logic [63:0] lo_mask;
      logic rb;
      logic st;
      logic [31:0] res;
      minq = 13'(1 - bias - fb);
      q = 13'(e) + $signed({6'b0, nb}) - 13'(fb + 1);
      if (q < minq) q = minq;
      drop = q - 13'(e);
      m = '0;
      if (drop <= 13'sd0) begin
         m = r << 6'(-drop);
      end else if (drop >= 13'sd64) begin
         m = '0;
      end else begin
         lo_mask = (64'd1 << 6'(drop - 13'sd1)) - 64'd1;
         rb = r[6'(drop - 13'sd1)];
         st = |(r & lo_mask);
         m = r >> 6'(drop);
         if (rb && (st || m[0])) m = m + 64'd1;
         if ((m >> (fb + 1)) != '0) begin
            m = m >> 1;
            q = q + 13'sd1;
         end
      end
      if (m == '0) begin
         res = sign;
      end else if (m < (64'd1 << fb)) begin
         res = sign | 32'(m);
      end else begin
         biased = q + 13'(fb + bias);
         if (biased >= 13'(emax)) res = sign | (32'(emax) << fb);
         else res = sign | (32'(biased) << fb) | 32'(m & ((64'd1 << fb) - 64'd1));
      end
      return res;
   endfunction

endpackage

FILE: sv/gated_linear_scan_narrow_state.sv
// Gated linear scan: per channel, s = gate * s + addend as a fused fp32 multiply-add.
// Request words (req_valid/req_stall) carry a channel, gate, addend and end_of_call flag;
// each produces one response word (rsp_valid/rsp_stall) with the new fp32 accumulator,
// the channel, and on end_of_call the fp16 or bf16 state word picked by the csr bit.
// On end_of_call the stored accumulator is replaced by the widened narrow word.
// Throughput: one word per cycle while rsp_stall is low and no word reuses a channel of the
// nine words before it. The accumulators sit in one memory read at accept and written back
// from stage 9; a word whose channel is still in that read-modify-write window is held off
// by an interlock, so repeated updates of one channel wait until the earlier word leaves stage 9.
// Reset starts a clearing pass that zeroes every accumulator; requests are stalled until it
// ends, csr writes are taken throughout.
// A stalled response holds in the output register; the pipeline behind it keeps filling
// its empty stages and only stalls requests once no stage can move.
module gated_linear_scan_narrow_state
   import gls_pkg::*;
#(
   parameter int CHANNELS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_channel,
   input  logic [31:0] req_gate,
   input  logic [31:0] req_addend,
   input  logic        req_end_of_call,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_scan_out,
   output logic [11:0] rsp_out_channel,
   output logic [15:0] rsp_narrow_state,
   output logic        rsp_state_stored,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int NS = 10;

   logic [31:0] mem [CHANNELS];
   logic [31:0] rdata_ff;

   logic          clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;
   logic          fmt_ff;

   logic        vld_ff [1:NS];
   logic        rdy    [1:NS];
   logic [11:0] ch_ff  [1:NS];
   logic        eoc_ff [1:NS];
   logic        inr_ff [1:NS];

   logic accept;
   logic hazard;
   logic inr_in;

   // stage 1: operands
   logic [31:0] s1_gate_ff, s1_add_ff;
   logic [31:0] op_b;
   logic        spc1_in;
   logic [31:0] spv1_in;
   logic        sp_in;
   logic [47:0] mp_in;

   // stage 2
   logic [47:0] s2_mp_ff;
   logic [23:0] s2_mc_ff;
   logic signed [11:0] s2_ep_ff, s2_ec_ff;
   logic        s2_sp_ff, s2_sc_ff, s2_spc_ff;
   logic [31:0] s2_c_ff, s2_spv_ff;
   logic [6:0]  nbp_in, nbc_in;
   logic        spc2_in;
   logic [31:0] spv2_in;

   // stage 3
   logic [47:0] s3_mp_ff;
   logic [23:0] s3_mc_ff;
   logic signed [11:0] s3_ep_ff, s3_ec_ff;
   logic        s3_sp_ff, s3_sc_ff, s3_spc_ff;
   logic [31:0] s3_spv_ff;
   logic [6:0]  s3_nbp_ff, s3_nbc_ff;
   logic        prod_big;
   logic [63:0] ml, ms, a_in, b_in;
   logic [6:0]  nl;
   logic signed [11:0] el, es, e_in, sh, k;
   logic        sl, ss;

   // stage 4
   logic [63:0] s4_a_ff, s4_b_ff;
   logic signed [11:0] s4_e_ff;
   logic        s4_sl_ff, s4_ss_ff, s4_spc_ff;
   logic [31:0] s4_spv_ff;
   logic [63:0] r_in;
   logic        sgn_in;

   // stage 5 and 6
   logic [63:0] s5_r_ff, s6_r_ff;
   logic signed [11:0] s5_e_ff, s6_e_ff;
   logic        s5_sgn_ff, s6_sgn_ff, s5_spc_ff, s6_spc_ff;
   logic [31:0] s5_spv_ff, s6_spv_ff;
   logic [6:0]  s6_nb_ff;
   logic [31:0] res_in;

   // stage 7: narrowing prep
   logic [31:0] s7_r_ff;
   logic        hspc_in;
   logic [15:0] hspv_in, bf_in;
   logic [31:0] bf_t;

   // stage 8
   logic [31:0] s8_r_ff;
   logic        s8_hspc_ff;
   logic [15:0] s8_hspv_ff, s8_bf_ff;
   logic [23:0] s8_hm_ff;
   logic signed [11:0] s8_he_ff;
   logic [6:0]  s8_hnb_ff;
   logic [31:0] h_full;
   logic [15:0] narrow_in;

   // stage 9 and output
   logic [31:0] s9_r_ff, s10_r_ff;
   logic [15:0] s9_n_ff, s10_n_ff;
   logic [31:0] kept;
   logic [6:0]  nbf;
   logic [23:0] fsh;
   logic        wr;
   logic        mem_we;
   logic [AW-1:0] mem_waddr;
   logic [31:0] mem_wdata;

   // handshake and interlock
   always_comb begin
      rdy[NS] = !vld_ff[NS] || !rsp_stall;
      for (int i = NS - 1; i >= 1; i--) rdy[i] = !vld_ff[i] || rdy[i + 1];
      hazard = 1'b0;
      for (int i = 1; i < NS; i++) begin
         if (vld_ff[i] && (ch_ff[i] == req_channel)) hazard = 1'b1;
      end
   end

   assign req_stall = clr_busy_ff || !rdy[1] || hazard;
   assign accept    = req_valid && !req_stall;
   assign inr_in    = 32'(req_channel) < CHANNELS;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         fmt_ff      <= 1'b0;
         for (int i = 1; i <= NS; i++) vld_ff[i] <= 1'b0;
      end else begin
         if (csr_wr_en) fmt_ff <= csr_wr_data;
         if (clr_busy_ff) begin
            if (clr_addr_ff == AW'(CHANNELS - 1)) clr_busy_ff <= 1'b0;
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (rdy[1]) vld_ff[1] <= accept;
         for (int i = 2; i <= NS; i++) begin
            if (rdy[i]) vld_ff[i] <= vld_ff[i - 1];
         end
      end
   end

   // tag shift line
   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         ch_ff[1]  <= req_channel;
         eoc_ff[1] <= req_end_of_call;
         inr_ff[1] <= inr_in;
      end
      for (int i = 2; i <= NS; i++) begin
         if (rdy[i]) begin
            ch_ff[i]  <= ch_ff[i - 1];
            eoc_ff[i] <= eoc_ff[i - 1];
            inr_ff[i] <= inr_ff[i - 1];
         end
      end
   end

   // accumulator memory: clearing pass, write back, read at accept
   assign wr        = vld_ff[9] && rdy[10] && inr_ff[9];
   assign mem_we    = clr_busy_ff || wr;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : AW'(ch_ff[9]);
   assign mem_wdata = clr_busy_ff ? 32'h0 : kept;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (rdy[1]) rdata_ff <= mem[AW'(req_channel)];
   end

   // stage 1: specials and mantissa product
   always_comb begin
      op_b  = inr_ff[1] ? rdata_ff : 32'h0;
      sp_in = s1_gate_ff[31] ^ op_b[31];
      spc1_in = 1'b1;
      spv1_in = QNAN32;
      if (is_nan32(s1_gate_ff) || is_nan32(op_b) || is_nan32(s1_add_ff)) begin
         spv1_in = QNAN32;
      end else if (is_inf32(s1_gate_ff) || is_inf32(op_b)) begin
         if (is_zero32(s1_gate_ff) || is_zero32(op_b)) spv1_in = QNAN32;
         else if (is_inf32(s1_add_ff) && (s1_add_ff[31] != sp_in)) spv1_in = QNAN32;
         else spv1_in = {sp_in, 31'h0} | INF32;
      end else if (is_inf32(s1_add_ff)) begin
         spv1_in = s1_add_ff;
      end else begin
         spc1_in = 1'b0;
      end
      mp_in = unp_man(s1_gate_ff) * unp_man(op_b);
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_gate_ff <= req_gate;
         s1_add_ff  <= req_addend;
      end
      if (rdy[2]) begin
         s2_mp_ff  <= mp_in;
         s2_mc_ff  <= unp_man(s1_add_ff);
         s2_ep_ff  <= unp_exp(s1_gate_ff) + unp_exp(op_b);
         s2_ec_ff  <= unp_exp(s1_add_ff);
         s2_sp_ff  <= sp_in;
         s2_sc_ff  <= s1_add_ff[31];
         s2_c_ff   <= s1_add_ff;
         s2_spc_ff <= spc1_in;
         s2_spv_ff <= spv1_in;
      end
   end

   // stage 2: operand lengths, zero product
   always_comb begin
      nbp_in  = bit_len64(64'(s2_mp_ff));
      nbc_in  = bit_len64(64'(s2_mc_ff));
      spc2_in = s2_spc_ff;
      spv2_in = s2_spv_ff;
      if (!s2_spc_ff && (nbp_in == '0)) begin
         spc2_in = 1'b1;
         if (s2_mc_ff != '0) spv2_in = s2_c_ff;
         else if (s2_sp_ff == s2_sc_ff) spv2_in = {s2_sp_ff, 31'h0};
         else spv2_in = 32'h0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s3_mp_ff  <= s2_mp_ff;
         s3_mc_ff  <= s2_mc_ff;
         s3_ep_ff  <= s2_ep_ff;
         s3_ec_ff  <= s2_ec_ff;
         s3_sp_ff  <= s2_sp_ff;
         s3_sc_ff  <= s2_sc_ff;
         s3_nbp_ff <= nbp_in;
         s3_nbc_ff <= nbc_in;
         s3_spc_ff <= spc2_in;
         s3_spv_ff <= spv2_in;
      end
   end

   // stage 3: align the smaller operand, keep a sticky bit
   always_comb begin
      prod_big = (s3_mc_ff == '0) ||
                 ((s3_ep_ff + $signed({5'b0, s3_nbp_ff})) >=
                  (s3_ec_ff + $signed({5'b0, s3_nbc_ff})));
      if (prod_big) begin
         ml = 64'(s3_mp_ff); nl = s3_nbp_ff; el = s3_ep_ff; sl = s3_sp_ff;
         ms = 64'(s3_mc_ff); es = s3_ec_ff; ss = s3_sc_ff;
      end else begin
         ml = 64'(s3_mc_ff); nl = s3_nbc_ff; el = s3_ec_ff; sl = s3_sc_ff;
         ms = 64'(s3_mp_ff); es = s3_ep_ff; ss = s3_sp_ff;
      end
      e_in = el - (12'sd62 - $signed({5'b0, nl}));
      a_in = ml << (7'd62 - nl);
      sh   = es - e_in;
      k    = -sh;
      if (ms == '0) begin
         b_in = '0;
      end else if (!sh[11]) begin
         b_in = ms << sh[5:0];
      end else if (k >= 12'sd64) begin
         b_in = 64'd1;
      end else begin
         b_in = (ms >> k[5:0]) | 64'(|(ms & ((64'd1 << k[5:0]) - 64'd1)));
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s4_a_ff   <= a_in;
         s4_b_ff   <= b_in;
         s4_e_ff   <= e_in;
         s4_sl_ff  <= sl;
         s4_ss_ff  <= ss;
         s4_spc_ff <= s3_spc_ff;
         s4_spv_ff <= s3_spv_ff;
      end
   end

   // stage 4: add or subtract magnitudes
   always_comb begin
      if (s4_sl_ff == s4_ss_ff) begin
         r_in = s4_a_ff + s4_b_ff;  sgn_in = s4_sl_ff;
      end else if (s4_a_ff >= s4_b_ff) begin
         r_in = s4_a_ff - s4_b_ff;  sgn_in = s4_sl_ff;
      end else begin
         r_in = s4_b_ff - s4_a_ff;  sgn_in = s4_ss_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         s5_r_ff   <= r_in;
         s5_e_ff   <= s4_e_ff;
         s5_sgn_ff <= sgn_in;
         s5_spc_ff <= s4_spc_ff;
         s5_spv_ff <= s4_spv_ff;
      end
      if (rdy[6]) begin
         s6_r_ff   <= s5_r_ff;
         s6_e_ff   <= s5_e_ff;
         s6_sgn_ff <= s5_sgn_ff;
         s6_nb_ff  <= bit_len64(s5_r_ff);
         s6_spc_ff <= s5_spc_ff;
         s6_spv_ff <= s5_spv_ff;
      end
   end

   // stage 6: round to fp32; an exact zero sum gives +0
   always_comb begin
      if (s6_spc_ff) res_in = s6_spv_ff;
      else if (s6_nb_ff == '0) res_in = 32'h0;
      else res_in = round_pack({s6_sgn_ff, 31'h0}, s6_r_ff, s6_e_ff, s6_nb_ff, 23, 127, 255);
   end

   always_ff @(posedge clock) begin
      if (rdy[7]) s7_r_ff <= res_in;
   end

   // stage 7: fp16 specials, bf16 bias rounding
   always_comb begin
      hspc_in = 1'b1;
      if (s7_r_ff[30:23] == F32_EMAX) begin
         if (s7_r_ff[22:0] != '0) hspv_in = {s7_r_ff[31], 15'h0} | F16_QNAN | 16'(s7_r_ff[22:13]);
         else hspv_in = {s7_r_ff[31], 15'h0} | F16_INF;
      end else if (is_zero32(s7_r_ff)) begin
         hspv_in = {s7_r_ff[31], 15'h0};
      end else begin
         hspc_in = 1'b0;
         hspv_in = '0;
      end
      bf_t  = s7_r_ff + BF16_BIAS + 32'(s7_r_ff[16]);
      bf_in = bf_t[31:16];
   end

   always_ff @(posedge clock) begin
      if (rdy[8]) begin
         s8_r_ff    <= s7_r_ff;
         s8_hspc_ff <= hspc_in;
         s8_hspv_ff <= hspv_in;
         s8_bf_ff   <= bf_in;
         s8_hm_ff   <= unp_man(s7_r_ff);
         s8_he_ff   <= unp_exp(s7_r_ff);
         s8_hnb_ff  <= bit_len64(64'(unp_man(s7_r_ff)));
      end
   end

   // stage 8: fp16 rounding, select the narrow word
   always_comb begin
      h_full = round_pack({16'h0, s8_r_ff[31], 15'h0}, 64'(s8_hm_ff), s8_he_ff, s8_hnb_ff,
                          10, 15, 31);
      if (!eoc_ff[8]) narrow_in = '0;
      else if (fmt_ff) narrow_in = s8_bf_ff;
      else if (s8_hspc_ff) narrow_in = s8_hspv_ff;
      else narrow_in = h_full[15:0];
   end

   always_ff @(posedge clock) begin
      if (rdy[9]) begin
         s9_r_ff <= s8_r_ff;
         s9_n_ff <= narrow_in;
      end
      if (rdy[10]) begin
         s10_r_ff <= s9_r_ff;
         s10_n_ff <= s9_n_ff;
      end
   end

   // stage 9: widen the narrow word back to fp32 for write back
   always_comb begin
      nbf = bit_len64(64'(s9_n_ff[9:0]));
      fsh = 24'(s9_n_ff[9:0]) << (7'd24 - nbf);
      if (!eoc_ff[9]) begin
         kept = s9_r_ff;
      end else if (fmt_ff) begin
         kept = {s9_n_ff, 16'h0};
      end else if (s9_n_ff[14:10] == F16_EMAX) begin
         kept = {s9_n_ff[15], F32_EMAX, s9_n_ff[9:0], 13'h0};
      end else if (s9_n_ff[14:10] == '0) begin
         if (s9_n_ff[9:0] == '0) kept = {s9_n_ff[15], 31'h0};
         else kept = {s9_n_ff[15], 8'(nbf + 7'd102), fsh[22:0]};
      end else begin
         kept = {s9_n_ff[15], 8'(s9_n_ff[14:10]) + 8'd112, s9_n_ff[9:0], 13'h0};
      end
   end

   assign rsp_valid        = vld_ff[NS];
   assign rsp_scan_out     = s10_r_ff;
   assign rsp_out_channel  = ch_ff[NS];
   assign rsp_narrow_state = s10_n_ff;
   assign rsp_state_stored = eoc_ff[NS];

endmodule

FILE: verif/gated_linear_scan_narrow_state_tb.sv
`timescale 1ns / 100ps

module gated_linear_scan_narrow_state_tb
   import gls_pkg::*;
();

   localparam int NUM_CH = 4096;
   localparam logic FMT_FP16 = 1'b0;
   localparam logic FMT_BF16 = 1'b1;

   typedef struct {
      logic [31:0] scan;
      logic [11:0] ch;
      logic [15:0] narrow;
      logic        stored;
   } scan_word_type;

   typedef struct {
      logic [11:0] ch;
      logic [31:0] gate;
      logic [31:0] addend;
      logic        eoc;
      logic        typed;
      logic [31:0] scan;
      logic [15:0] narrow;
   } stim_row_type;

   logic        clock, reset;
   logic        req_valid, req_stall, req_end_of_call;
   logic [11:0] req_channel;
   logic [31:0] req_gate, req_addend;
   logic        rsp_valid, rsp_stall, rsp_state_stored;
   logic [31:0] rsp_scan_out;
   logic [11:0] rsp_out_channel;
   logic [15:0] rsp_narrow_state;
   logic        csr_wr_en, csr_wr_data;

   logic [31:0]   acc_model [NUM_CH];
   logic          fmt_model;
   scan_word_type pending_q[$];
   int            mismatches;
   int            stall_mode;

   gated_linear_scan_narrow_state #(.CHANNELS(NUM_CH)) dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("[gated_linear_scan_narrow_state] ERROR");
      $finish;
   end

   function automatic int msb_count(longint unsigned v);
      int n;
      n = 0;
      while (v != 0) begin
         v = v >> 1;
         n++;
      end
      return n;
   endfunction

   // Round nonzero r * 2^e to fb fraction bits, nearest even, overflow to inf.
   function automatic logic [31:0] round_to_fmt(logic [31:0] sgn, longint unsigned r, int e,
                                                 int fb, int bias, int emax);
      int q, minq, drop;
      longint unsigned m, rem, half;
      minq = 1 - bias - fb;
      q = e + msb_count(r) - (fb + 1);
      if (q < minq) q = minq;
      drop = q - e;
      if (drop <= 0) begin
         m = r << (-drop);
      end else if (drop >= 64) begin
         m = 0;
      end else begin
         rem = r & ((64'd1 << drop) - 1);
         half = 64'd1 << (drop - 1);
         m = r >> drop;
         if (rem > half || (rem == half && m[0])) m++;
         if ((m >> (fb + 1)) != 0) begin
            m = m >> 1;
            q++;
         end
      end
      if (m == 0) return sgn;
      if (m < (64'd1 << fb)) return sgn | 32'(m);
      if (q + fb + bias >= emax) return sgn | (32'(emax) << fb);
      return sgn | (32'(q + fb + bias) << fb) | 32'(m & ((64'd1 << fb) - 1));
   endfunction

   function automatic void split_f32(logic [31:0] b, output longint unsigned m, output int e);
      if (b[30:23] == 0) begin
         m = b[22:0];
         e = -149;
      end else begin
         m = {1'b1, b[22:0]};
         e = int'(b[30:23]) - 150;
      end
   endfunction

   function automatic logic f_nan(logic [31:0] b);
      return b[30:23] == 8'hFF && b[22:0] != 0;
   endfunction

   function automatic logic f_inf(logic [31:0] b);
      return b[30:0] == 31'h7F80_0000;
   endfunction

   function automatic logic [31:0] fused_mac(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      logic [31:0] sp, sc, s_big, s_sml, sgn;
      longint unsigned ma, mb, mc, mp, m_big, m_sml, wa, wb, sum;
      int ea, eb, ec, ep, e_big, e_sml, n_big, ebase, sh;
      sp = (a ^ b) & 32'h8000_0000;
      sc = c & 32'h8000_0000;
      if (f_nan(a) || f_nan(b) || f_nan(c)) return QNAN32;
      if (f_inf(a) || f_inf(b)) begin
         if (a[30:0] == 0 || b[30:0] == 0) return QNAN32;
         if (f_inf(c) && sc != sp) return QNAN32;
         return sp | INF32;
      end
      if (f_inf(c)) return c;
      split_f32(a, ma, ea);
      split_f32(b, mb, eb);
      split_f32(c, mc, ec);
      mp = ma * mb;
      ep = ea + eb;
      if (mp == 0) begin
         if (mc == 0) return (sp == sc) ? sp : 32'h0;
         return c;
      end
      if (mc == 0) return round_to_fmt(sp, mp, ep, 23, 127, 255);
      if (ep + msb_count(mp) >= ec + msb_count(mc)) begin
         m_big = mp; e_big = ep; s_big = sp; m_sml = mc; e_sml = ec; s_sml = sc;
      end else begin
         m_big = mc; e_big = ec; s_big = sc; m_sml = mp; e_sml = ep; s_sml = sp;
      end
      n_big = msb_count(m_big);
      ebase = e_big - (62 - n_big);
      wa = m_big << (62 - n_big);
      sh = e_sml - ebase;
      if (sh >= 0) wb = m_sml << sh;
      else if (-sh >= 64) wb = 1;
      else wb = (m_sml >> (-sh)) | longint'((m_sml & ((64'd1 << (-sh)) - 1)) != 0);
      if (s_big == s_sml) begin
         sum = wa + wb; sgn = s_big;
      end else if (wa >= wb) begin
         sum = wa - wb; sgn = s_big;
      end else begin
         sum = wb - wa; sgn = s_sml;
      end
      if (sum == 0) return 32'h0;
      return round_to_fmt(sgn, sum, ebase, 23, 127, 255);
   endfunction

   function automatic logic [15:0] to_half(logic [31:0] b);
      longint unsigned m;
      int e;
      if (b[30:23] == 8'hFF) begin
         if (b[22:0] != 0) return {b[31], 15'h0} | F16_QNAN | 16'(b[22:13]);
         return {b[31], 15'h0} | F16_INF;
      end
      if (b[30:0] == 0) return {b[31], 15'h0};
      split_f32(b, m, e);
      return 16'(round_to_fmt({16'h0, b[31], 15'h0}, m, e, 10, 15, 31));
   endfunction

   function automatic logic [31:0] from_half(logic [15:0] h);
      logic [31:0] s;
      s = {h[15], 31'h0};
      if (h[14:10] == 5'h1F) return s | INF32 | {9'h0, h[9:0], 13'h0};
      if (h[14:10] == 0) begin
         if (h[9:0] == 0) return s;
         return round_to_fmt(s, h[9:0], -24, 23, 127, 255);
      end
      return s | {1'b0, 8'(h[14:10] + 112), h[9:0], 13'h0};
   endfunction

   function automatic scan_word_type scan_update(logic [11:0] ch, logic [31:0] g,
                                                 logic [31:0] x, logic eoc);
      scan_word_type w;
      logic [31:0] kept, biased;
      w.scan = fused_mac(g, acc_model[ch], x);
      w.ch = ch;
      w.narrow = '0;
      w.stored = eoc;
      kept = w.scan;
      if (eoc) begin
         if (fmt_model == FMT_BF16) begin
            biased = w.scan + BF16_BIAS + w.scan[16];
            w.narrow = biased[31:16];
            kept = {w.narrow, 16'h0};
         end else begin
            w.narrow = to_half(w.scan);
            kept = from_half(w.narrow);
         end
      end
      acc_model[ch] = kept;
      return w;
   endfunction

   // Drive one word at the falling edge, hold until taken, then queue its result.
   task automatic send_word(stim_row_type r);
      scan_word_type w;
      req_channel = r.ch;
      req_gate = r.gate;
      req_addend = r.addend;
      req_end_of_call = r.eoc;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      w = scan_update(r.ch, r.gate, r.addend, r.eoc);
      if (r.typed) begin
         w.scan = r.scan;
         w.narrow = r.narrow;
      end
      pending_q.push_back(w);
      @(negedge clock);
   endtask

   task automatic set_format(logic fmt);
      wait (pending_q.size() == 0);
      repeat (12) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = fmt;
      @(negedge clock);
      csr_wr_en = 1'b0;
      fmt_model = fmt;
   endtask

   function automatic logic [31:0] pick_f32(logic is_gate);
      case ($urandom_range(0, 11))
         0: return $urandom();
         1: return {$urandom_range(0, 1) == 1, 31'h0};
         2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'h0};
         3: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
         4: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom())};
         5: return {$urandom_range(0, 1) == 1, 8'($urandom_range(240, 254)), 23'($urandom())};
         6: return {$urandom_range(0, 1) == 1, 8'($urandom_range(1, 20)), 23'($urandom())};
         7: return {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 118)), 23'($urandom())};
         default:
            if (is_gate) return {1'b0, 8'($urandom_range(124, 126)), 23'($urandom())};
            else return {$urandom_range(0, 1) == 1, 8'($urandom_range(110, 145)), 23'($urandom())};
      endcase
   endfunction

   // Receiver stall pattern: free-running, changes its density now and then.
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ~rsp_stall;
      endcase
   end

   always @(posedge clock) begin
      scan_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word: ch %0d scan %h", rsp_out_channel, rsp_scan_out);
         end else begin
            w = pending_q.pop_front();
            if (rsp_scan_out !== w.scan || rsp_out_channel !== w.ch
                || rsp_narrow_state !== w.narrow || rsp_state_stored !== w.stored) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("exp ch %0d %h %h %b, got ch %0d %h %h %b",
                           w.ch, w.scan, w.narrow, w.stored, rsp_out_channel, rsp_scan_out,
                           rsp_narrow_state, rsp_state_stored);
            end
         end
      end
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type r;
      int burst, n;
      mismatches = 0;
      stall_mode = 0;
      rsp_stall = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_channel = '0;
      req_gate = '0;
      req_addend = '0;
      req_end_of_call = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      fmt_model = FMT_FP16;
      foreach (acc_model[i]) acc_model[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      set_format(FMT_FP16);

      //       ch       gate          addend        eoc  typed scan          narrow
      rows = '{
         '{12'd5,    32'h4000_0000, 32'h3F80_0000, 0, 1, 32'h3F80_0000, 16'h0},
         '{12'd6,    32'h3F80_0000, 32'h7FA1_2345, 0, 1, QNAN32,        16'h0},
         '{12'd7,    INF32,         32'h3F80_0000, 0, 1, QNAN32,        16'h0},
         '{12'd8,    32'h0000_0000, 32'h3F80_0000, 1, 1, 32'h3F80_0000, 16'h3C00},
         '{12'd9,    32'h8000_0000, 32'h8000_0000, 0, 1, 32'h8000_0000, 16'h0},
         '{12'd10,   32'h3F80_0000, 32'h7FA1_2345, 1, 1, QNAN32,        16'h7E00},
         '{12'd11,   32'h3F80_0000, 32'h4780_0000, 1, 1, 32'h4780_0000, 16'h7C00},
         '{12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, QNAN32,        16'h0},
         '{12'd5,    32'h7F7F_FFFF, 32'h7F7F_FFFF, 0, 0, 32'h0,         16'h0},
         '{12'd5,    32'hBF80_0000, 32'hFF80_0000, 0, 0, 32'h0,         16'h0},
         '{12'd8,    32'h3F80_0000, 32'hBF80_0000, 0, 0, 32'h0,         16'h0},
         '{12'd12,   32'h3F80_0000, 32'h0000_0001, 1, 0, 32'h0,         16'h0},
         '{12'd12,   32'h7F7F_FFFF, 32'h8000_0001, 0, 0, 32'h0,         16'h0},
         '{12'd13,   32'h3F80_0000, 32'h3880_1000, 1, 0, 32'h0,         16'h0},
         '{12'd14,   32'h3F80_0000, 32'h477F_F000, 1, 0, 32'h0,         16'h0},
         '{12'd15,   32'h3F80_0000, 32'h3F80_0FFF, 0, 0, 32'h0,         16'h0},
         '{12'd15,   32'h3F80_0000, 32'h0000_0000, 1, 0, 32'h0,         16'h0},
         '{12'd0,    32'h0000_0001, 32'h0080_0000, 0, 0, 32'h0,         16'h0},
         '{12'd0,    32'h3F00_0000, 32'h807F_FFFF, 1, 0, 32'h0,         16'h0},
         '{12'd1,    32'h3F80_0000, 32'hFF7F_FFFF, 0, 0, 32'h0,         16'h0},
         '{12'd1,    32'h3F80_0000, 32'hFF7F_FFFF, 1, 0, 32'h0,         16'h0}
      };
      foreach (rows[i]) send_word(rows[i]);
      req_valid = 1'b0;

      for (int phase = 0; phase < 6; phase++) begin
         set_format(phase[0] ? FMT_BF16 : FMT_FP16);
         n = 0;
         burst = 0;
         while (n < 125) begin
            r.ch = ($urandom_range(0, 4) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 7));
            r.gate = pick_f32(1'b1);
            r.addend = pick_f32(1'b0);
            r.eoc = ($urandom_range(0, 5) == 0);
            r.typed = 1'b0;
            r.scan = '0;
            r.narrow = '0;
            send_word(r);
            n++;
            // Bursty sender, except in every third phase where it streams back to back.
            if (phase % 3 != 2) begin
               if (burst == 0) begin
                  req_valid = 1'b0;
                  repeat ($urandom_range(1, 6)) @(negedge clock);
                  burst = $urandom_range(1, 20);
               end else begin
                  burst--;
               end
            end
         end
         req_valid = 1'b0;
      end

      wait (pending_q.size() == 0);
      repeat (30) @(posedge clock);
      if (mismatches == 0 && pending_q.size() == 0)
         $display("[gated_linear_scan_narrow_state] OK");
      else
         $display("[gated_linear_scan_narrow_state] ERROR");
      $finish;
   end

endmodule

FILE: gated_linear_scan_narrow_state.f
sv/gls_pkg.sv
sv/gated_linear_scan_narrow_state.sv
verif/gated_linear_scan_narrow_state_tb.sv
